FILE: design/mexp_pkg.sv
// shared constants and types for the modular exponentiation core
package mexp_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS);
    localparam int SUM_BITS     = OPERAND_BITS + 2;

    typedef logic [OPERAND_BITS-1:0] operand_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MULT,
        ST_SQUARE,
        ST_FINISH
    } mexp_state_t;

endpackage

FILE: design/modular_exponentiation_core.sv
// top level: modulus register, square-and-multiply sequencer and result register
// One item at a time: an item is taken only while the sequencer is idle, and its result
// is held in an output register so that the next item can be taken while the result
// waits. Every modular product goes through one shared bit-serial multiplier at one
// multiplier bit per cycle. An item costs one reduction of the base plus k products,
// where k is the number of one bits in the exponent plus the position of its highest
// one bit. A modulus below two gives 0 without any product. The user must write the
// modulus only while the block is idle; the block itself does not enforce this.
module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  operand_t cfg_wdata,
    input  logic     item_valid,
    output logic     item_stall,
    input  operand_t base_value,
    input  operand_t exponent,
    output logic     result_valid,
    input  logic     result_stall,
    output operand_t power_residue
);

    mexp_state_t state_reg;
    mexp_state_t state_next;
    logic        go_reg;
    logic        go_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    operand_t    modulus_reg;
    operand_t    base_reg;
    operand_t    base_next;
    operand_t    exp_reg;
    operand_t    exp_next;
    operand_t    sq_reg;
    operand_t    sq_next;
    operand_t    acc_reg;
    operand_t    acc_next;
    operand_t    res_reg;
    operand_t    res_next;

    operand_t    mul_a;
    operand_t    mul_b;
    logic        mul_done;
    operand_t    mul_product;

    mexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go_reg),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .modulus (modulus_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        case (state_reg)
            ST_REDUCE:
            begin
                mul_a = operand_t'(1);
                mul_b = base_reg;
            end
            ST_MULT:
            begin
                mul_a = acc_reg;
                mul_b = sq_reg;
            end
            default:
            begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        base_next      = base_reg;
        exp_next       = exp_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    base_next = base_value;
                    exp_next  = exponent;
                    acc_next  = operand_t'(1);
                    if (modulus_reg < operand_t'(2))
                    begin
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    sq_next = mul_product;
                    if (exp_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (exp_reg[0])
                    begin
                        state_next = ST_MULT;
                        go_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SQUARE;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_MULT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_product;
                    if (exp_reg[OPERAND_BITS-1:1] == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SQUARE;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    sq_next  = mul_product;
                    exp_next = exp_reg >> 1;
                    go_next  = 1'b1;
                    if (exp_reg[1])
                    begin
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    res_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= operand_t'(2);
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        sq_reg   <= sq_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign item_stall    = (state_reg != ST_IDLE);
    assign result_valid  = out_valid_reg;
    assign power_residue = res_reg;

endmodule

FILE: design/mexp_modmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module mexp_modmul
    import mexp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  operand_t mul_a,
    input  operand_t mul_b,
    input  operand_t modulus,
    output logic     done,
    output operand_t product
);

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    operand_t            a_reg;
    operand_t            a_next;
    operand_t            b_reg;
    operand_t            b_next;
    operand_t            acc_reg;
    operand_t            acc_next;

    logic [SUM_BITS-1:0] sum;
    logic [SUM_BITS-1:0] mod_x1;
    logic [SUM_BITS-1:0] mod_x2;
    operand_t            acc_step;

    // 2*acc + bit*a stays below 3*m, so one of three candidates is the residue
    always_comb
    begin
        sum    = {1'b0, acc_reg, 1'b0} + (b_reg[OPERAND_BITS-1] ? SUM_BITS'(a_reg) : '0);
        mod_x1 = SUM_BITS'(modulus);
        mod_x2 = {1'b0, modulus, 1'b0};
        if (sum >= mod_x2)
        begin
            acc_step = operand_t'(sum - mod_x2);
        end
        else if (sum >= mod_x1)
        begin
            acc_step = operand_t'(sum - mod_x1);
        end
        else
        begin
            acc_step = operand_t'(sum);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(OPERAND_BITS - 1);
            a_next    = mul_a;
            b_next    = mul_b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_step;
            b_next   = {b_reg[OPERAND_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: design/mexp_checker.sv
// port-level checks for the modular exponentiation core, bound to the top level
module mexp_checker
    import mexp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     item_valid,
    input logic     item_stall,
    input logic     result_valid,
    input logic     result_stall,
    input operand_t power_residue
);

    // a taken item keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("block not busy after taking an item");

    // a new result appears only as the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !item_stall)
        else $error("result appeared while sequencer busy");

    // an idle cycle with no result shown is never directly followed by a new result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid && !item_stall) |=> !$rose(result_valid) || $past(item_stall))
        else $error("result without a preceding item");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(power_residue)))
        else $error("stalled result changed");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .power_residue (power_residue)
);
